// ===== src/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Operation kinds, result status codes and the controller command struct.
// No dependencies.
package spq_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DEL_MAX  = 2'd1,
        KIND_DEL_MIN  = 2'd2,
        KIND_PEEK     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic execute;   // carry out the latched request and load the result
    } spq_cmd_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
// Sequences capture and execution and owns both handshakes; uses spq_pkg.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_cmd_t cmd
);

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd.capture = (state_reg == IDLE) && s_valid;
        cmd.execute = (state_reg == EXEC) && (!m_valid_reg || m_ready);

        state_next = state_reg;
        unique case (state_reg)
            IDLE: if (s_valid) state_next = EXEC;
            EXEC: if (cmd.execute) state_next = IDLE;
            default: state_next = IDLE;
        endcase

        // A new result replaces the one taken in the same cycle.
        if (cmd.execute) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== src/spq_datapath.sv =====
// Datapath of the sorted priority queue: the sorted entry row, the count,
// the request latch and the result register. Uses spq_pkg.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int PRIO_WIDTH = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  spq_cmd_t              cmd,
    input  logic [1:0]            s_kind,
    input  logic [PRIO_WIDTH-1:0] s_priority_req,
    input  logic [DATA_WIDTH-1:0] s_payload,
    output logic [1:0]            m_status,
    output logic [DATA_WIDTH-1:0] m_out_payload,
    output logic [PRIO_WIDTH-1:0] m_out_priority,
    output logic [CNT_W-1:0]      m_occupancy
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic [PRIO_WIDTH-1:0] prio_reg [CAPACITY];
    logic [DATA_WIDTH-1:0] data_reg [CAPACITY];
    logic [PRIO_WIDTH-1:0] prio_next [CAPACITY];
    logic [DATA_WIDTH-1:0] data_next [CAPACITY];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    kind_t                 kind_reg;
    logic [PRIO_WIDTH-1:0] req_prio_reg;
    logic [DATA_WIDTH-1:0] req_data_reg;

    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [DATA_WIDTH-1:0] res_data_reg;
    logic [DATA_WIDTH-1:0] res_data_next;
    logic [PRIO_WIDTH-1:0] res_prio_reg;
    logic [PRIO_WIDTH-1:0] res_prio_next;

    logic [CAPACITY-1:0]   ge;
    logic                  is_full;
    logic                  is_empty;
    logic [CNT_W-1:0]      last_cnt;
    logic [IDX_W-1:0]      last_idx;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign last_cnt = count_reg - CNT_W'(1);
    assign last_idx = last_cnt[IDX_W-1:0];

    // Held entries at or above the new priority; sorting makes this a prefix.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] >= req_prio_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            prio_next[i] = prio_reg[i];
            data_next[i] = data_reg[i];
        end
        count_next    = count_reg;
        status_next   = STATUS_OK;
        res_data_next = '0;
        res_prio_next = '0;

        unique case (kind_reg)
            KIND_INSERT: begin
                if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    if (!ge[0]) begin
                        prio_next[0] = req_prio_reg;
                        data_next[0] = req_data_reg;
                    end
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (!ge[i]) begin
                            if (ge[i-1]) begin
                                prio_next[i] = req_prio_reg;
                                data_next[i] = req_data_reg;
                            end else begin
                                prio_next[i] = prio_reg[i-1];
                                data_next[i] = data_reg[i-1];
                            end
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_DEL_MIN: begin
                if (is_empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    res_prio_next = prio_reg[last_idx];
                    res_data_next = data_reg[last_idx];
                    count_next    = last_cnt;
                end
            end
            KIND_DEL_MAX, KIND_PEEK: begin
                if (is_empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    res_prio_next = prio_reg[0];
                    res_data_next = data_reg[0];
                    if (kind_reg == KIND_DEL_MAX) begin
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            prio_next[i] = prio_reg[i+1];
                            data_next[i] = data_reg[i+1];
                        end
                        count_next = last_cnt;
                    end
                end
            end
            default: status_next = STATUS_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg     <= kind_t'(s_kind);
            req_prio_reg <= s_priority_req;
            req_data_reg <= s_payload;
        end
        if (cmd.execute) begin
            for (int i = 0; i < CAPACITY; i++) begin
                prio_reg[i] <= prio_next[i];
                data_reg[i] <= data_next[i];
            end
            status_reg   <= status_next;
            res_data_reg <= res_data_next;
            res_prio_reg <= res_prio_next;
        end
    end

    // The count register already follows the result, so it doubles as occupancy.
    assign m_status       = status_reg;
    assign m_out_payload  = res_data_reg;
    assign m_out_priority = res_prio_reg;
    assign m_occupancy    = count_reg;

endmodule

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue.
// Instantiates spq_ctrl and spq_datapath; uses spq_pkg.
//
// Usage: each transaction on the s_ channel is one operation on a queue
// of up to CAPACITY priority/data pairs kept in descending priority order:
// insert (s_priority_req, s_payload), remove the highest, remove the
// lowest, or peek at the highest. Equal priorities leave oldest first
// from the top, newest first from the bottom. Every operation yields
// exactly one transaction on the m_ channel carrying a status (ok,
// empty, full), the affected entry (zero for inserts and failed
// operations) and the occupancy afterward.
// Each operation is captured in IDLE and executed in EXEC, where all
// entries compare against the new priority and shift together; no new
// operation is taken until the last has executed. The result sits in
// an output register, so the next operation is accepted while a
// result still waits. If the receiver stalls, the pending operation
// holds in EXEC until the output register frees; s_ready stays low.
// Reset (aresetn low, synchronous) empties the queue and drops any
// pending result; entry storage itself is not cleared.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int PRIO_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [PRIO_WIDTH-1:0]             s_priority_req,
    input  logic [DATA_WIDTH-1:0]             s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [DATA_WIDTH-1:0]             m_out_payload,
    output logic [PRIO_WIDTH-1:0]             m_out_priority,
    output logic [$clog2(CAPACITY + 1)-1:0]   m_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_cmd_t cmd;

    // The controller sequences each transaction; the datapath holds the
    // sorted entries and the result register.
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    spq_datapath #(
        .CAPACITY   (CAPACITY),
        .PRIO_WIDTH (PRIO_WIDTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_kind         (s_kind),
        .s_priority_req (s_priority_req),
        .s_payload      (s_payload),
        .m_status       (m_status),
        .m_out_payload  (m_out_payload),
        .m_out_priority (m_out_priority),
        .m_occupancy    (m_occupancy)
    );

    // An accepted operation is always executed before another is taken.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an operation was still pending");

    // Occupancy never exceeds the capacity.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= CNT_W'(CAPACITY)))
        else $error("occupancy above capacity");

    // A dropped insert is reported only when the queue is full.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_FULL) |-> (m_occupancy == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // An empty report leaves the queue empty and carries no entry.
    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_EMPTY) |->
        (m_occupancy == '0 && m_out_payload == '0 && m_out_priority == '0))
        else $error("empty status with entries held or data returned");

endmodule
